FILE: hdl/rc_channel_stick_switch_mapper_unit_defines.svh
// Assertion macros for the RC channel stick and switch mapper.
`ifndef RC_CHANNEL_STICK_SWITCH_MAPPER_UNIT_DEFINES_SVH
`define RC_CHANNEL_STICK_SWITCH_MAPPER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RCSM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcsm check failed");

// Next-cycle implication, checked outside reset.
`define RCSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcsm check failed");

`endif

FILE: hdl/rcsm_pkg.sv
// Shared constants, codes and types of the RC channel stick and switch mapper.
package rcsm_pkg;

    // Channel pulse width in bits.
    localparam int WIDTH_BITS  = 12;
    localparam int CH_W        = WIDTH_BITS;
    localparam int NUM_STICKS  = 4;
    localparam int NUM_CHANS   = 6;

    // Configuration register widths.
    localparam int CFG_LVL_W   = 12;
    localparam int CFG_MAX_W   = 14;
    localparam int CFG_MIN_W   = 15;
    localparam int CFG_DATA_W  = 15;
    localparam int CFG_IDX_W   = 3;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CENTER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STICK_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STICK_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SW_LOW    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SW_HIGH   = 3'd6;

    // Arithmetic widths: |width - center| * stick_max, then signed quotient.
    localparam int PROD_W      = CH_W + CFG_MAX_W;
    localparam int VAL_W       = PROD_W + 1;
    localparam int DIV_CNT_W   = $clog2(PROD_W + 1);
    localparam int STICK_W     = 15;

    // Switch position and edge codes.
    localparam int SW_W = 2;
    localparam logic [SW_W-1:0] POS_DOWN  = 2'd0;
    localparam logic [SW_W-1:0] POS_MID   = 2'd1;
    localparam logic [SW_W-1:0] POS_UP    = 2'd2;
    localparam logic [SW_W-1:0] EDGE_NONE = 2'd0;
    localparam logic [SW_W-1:0] EDGE_RISE = 2'd1;
    localparam logic [SW_W-1:0] EDGE_FALL = 2'd2;

    // Stream widths, rounded up to whole bytes.
    localparam int IN_DATA_W   = ((NUM_CHANS * CH_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = NUM_STICKS * STICK_W + 4 * SW_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int USER_W      = 2;

    // Divider request and response.
    typedef struct packed {
        logic                 start;
        logic [PROD_W-1:0]    dividend;
        logic [CFG_LVL_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [PROD_W-1:0] quotient;
    } t_div_rsp;

endpackage

FILE: hdl/rcsm_divider.sv
// Shared restoring divider, one quotient bit per cycle.
module rcsm_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rcsm_pkg::t_div_req i_req,
    output rcsm_pkg::t_div_rsp o_rsp
);

    logic [rcsm_pkg::PROD_W-1:0]    r_quo, n_quo;
    logic [rcsm_pkg::CFG_LVL_W-1:0] r_rem, n_rem;
    logic [rcsm_pkg::CFG_LVL_W-1:0] r_dvs, n_dvs;
    logic [rcsm_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic [rcsm_pkg::CFG_LVL_W:0]   w_shift;
    logic [rcsm_pkg::CFG_LVL_W+1:0] w_diff;

    // Shift in the next dividend bit and try the subtraction.
    assign w_shift = {r_rem, r_quo[rcsm_pkg::PROD_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_dvs};

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            // Treat a zero divisor as one.
            n_dvs  = (i_req.divisor == '0) ? {{(rcsm_pkg::CFG_LVL_W-1){1'b0}}, 1'b1}
                                           : i_req.divisor;
            n_cnt  = rcsm_pkg::PROD_W[rcsm_pkg::DIV_CNT_W-1:0];
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_quo = {r_quo[rcsm_pkg::PROD_W-2:0], ~w_diff[rcsm_pkg::CFG_LVL_W+1]};
            n_rem = w_diff[rcsm_pkg::CFG_LVL_W+1] ? w_shift[rcsm_pkg::CFG_LVL_W-1:0]
                                                  : w_diff[rcsm_pkg::CFG_LVL_W-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == {{(rcsm_pkg::DIV_CNT_W-1){1'b0}}, 1'b1}) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

FILE: hdl/rcsm_switch.sv
// Three-position switch decode with edge detection against the stored position.
module rcsm_switch (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_update,
    input  logic [rcsm_pkg::CH_W-1:0]      i_width,
    input  logic [rcsm_pkg::CFG_LVL_W-1:0] i_low,
    input  logic [rcsm_pkg::CFG_LVL_W-1:0] i_high,
    output logic [rcsm_pkg::SW_W-1:0]      o_position,
    output logic [rcsm_pkg::SW_W-1:0]      o_edge
);

    logic [rcsm_pkg::SW_W-1:0] r_prev;

    // Below low wins over above high.
    always_comb begin
        if (i_width < i_low) begin
            o_position = rcsm_pkg::POS_DOWN;
        end else if (i_width > i_high) begin
            o_position = rcsm_pkg::POS_UP;
        end else begin
            o_position = rcsm_pkg::POS_MID;
        end
        if (o_position > r_prev) begin
            o_edge = rcsm_pkg::EDGE_RISE;
        end else if (o_position < r_prev) begin
            o_edge = rcsm_pkg::EDGE_FALL;
        end else begin
            o_edge = rcsm_pkg::EDGE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= rcsm_pkg::POS_DOWN;
        end else if (i_update) begin
            r_prev <= o_position;
        end
    end

endmodule

FILE: hdl/rc_channel_stick_switch_mapper_unit.sv
// Top level of the RC channel stick and switch mapper.
// A new frame is taken only while idle, after the previous one has been loaded into the output
// register, which waits while the output side is stalled. Each of the four sticks goes through
// multiply, launch, 26 divider steps, quotient capture and post-scale; then the output load.
// Reset (synchronous, active low) restores the register defaults, clears both switch
// histories to down and empties the output register.
`include "rc_channel_stick_switch_mapper_unit_defines.svh"

module rc_channel_stick_switch_mapper_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port
    input  logic                             i_cfg_wr_en,
    input  logic [rcsm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rcsm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Input frame stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata, from bit 0: right_x_width, right_y_width, left_y_width, left_x_width,
    // left_switch_width, right_switch_width
    input  logic [rcsm_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // tuser, from bit 0: lost_in, failsafe_in
    input  logic [rcsm_pkg::USER_W-1:0]      i_s_axis_tuser,
    // Result stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // tdata, from bit 0: right_x, right_y, left_y, left_x, left_position,
    // right_position, left_edge, right_edge, zero fill
    output logic [rcsm_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // tuser, from bit 0: lost_out, failsafe_out
    output logic [rcsm_pkg::USER_W-1:0]      o_m_axis_tuser
);

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
    localparam logic [ST_W-1:0] ST_MUL    = 3'd1;
    localparam logic [ST_W-1:0] ST_LAUNCH = 3'd2;
    localparam logic [ST_W-1:0] ST_DIV    = 3'd3;
    localparam logic [ST_W-1:0] ST_POST   = 3'd4;
    localparam logic [ST_W-1:0] ST_FIN    = 3'd5;

    localparam int CHAN_IDX_W = $clog2(rcsm_pkg::NUM_STICKS);
    localparam int EXT_W      = rcsm_pkg::VAL_W - rcsm_pkg::CFG_MAX_W;
    localparam int SEXT_W     = rcsm_pkg::VAL_W - rcsm_pkg::CFG_MIN_W;

    // Configuration registers
    logic [rcsm_pkg::CFG_LVL_W-1:0] r_center;
    logic [rcsm_pkg::CFG_LVL_W-1:0] r_half;
    logic [rcsm_pkg::CFG_MAX_W-1:0] r_stick_max;
    logic [rcsm_pkg::CFG_MIN_W-1:0] r_stick_min;
    logic [rcsm_pkg::CFG_MAX_W-1:0] r_deadband;
    logic [rcsm_pkg::CFG_LVL_W-1:0] r_sw_low;
    logic [rcsm_pkg::CFG_LVL_W-1:0] r_sw_high;

    // Sequencer and working registers
    logic [ST_W-1:0]                r_state;
    logic [CHAN_IDX_W-1:0]          r_chan;
    logic [rcsm_pkg::CH_W-1:0]      r_width [rcsm_pkg::NUM_STICKS];
    logic [rcsm_pkg::STICK_W-1:0]   r_stick [rcsm_pkg::NUM_STICKS];
    logic [rcsm_pkg::SW_W-1:0]      r_lpos, r_rpos, r_ledge, r_redge;
    logic [rcsm_pkg::USER_W-1:0]    r_flags;
    logic [rcsm_pkg::PROD_W-1:0]    r_prod;
    logic                           r_neg;
    logic signed [rcsm_pkg::VAL_W-1:0] r_val;

    // Output register
    logic                           r_out_valid;
    logic [rcsm_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [rcsm_pkg::USER_W-1:0]    r_out_user;

    logic                           w_in_xfer;
    logic                           w_out_free;
    logic [rcsm_pkg::CH_W-1:0]      w_cur_width;
    logic [rcsm_pkg::CH_W-1:0]      w_mag;
    logic [rcsm_pkg::SW_W-1:0]      w_lpos, w_rpos, w_ledge, w_redge;
    logic signed [rcsm_pkg::VAL_W-1:0] w_hi, w_lo, w_db, w_clamp;
    logic [rcsm_pkg::STICK_W-1:0]   w_stick_res;
    logic                           w_pos_ok;
    rcsm_pkg::t_div_req             w_div_req;
    rcsm_pkg::t_div_rsp             w_div_rsp;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center    <= 12'd1500;
            r_half      <= 12'd500;
            r_stick_max <= 14'd1000;
            r_stick_min <= -15'sd1000;
            r_deadband  <= 14'd10;
            r_sw_low    <= 12'd1250;
            r_sw_high   <= 12'd1750;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                rcsm_pkg::REG_CENTER:    r_center    <= i_cfg_data[rcsm_pkg::CFG_LVL_W-1:0];
                rcsm_pkg::REG_HALF:      r_half      <= i_cfg_data[rcsm_pkg::CFG_LVL_W-1:0];
                rcsm_pkg::REG_STICK_MAX: r_stick_max <= i_cfg_data[rcsm_pkg::CFG_MAX_W-1:0];
                rcsm_pkg::REG_STICK_MIN: r_stick_min <= i_cfg_data[rcsm_pkg::CFG_MIN_W-1:0];
                rcsm_pkg::REG_DEADBAND:  r_deadband  <= i_cfg_data[rcsm_pkg::CFG_MAX_W-1:0];
                rcsm_pkg::REG_SW_LOW:    r_sw_low    <= i_cfg_data[rcsm_pkg::CFG_LVL_W-1:0];
                rcsm_pkg::REG_SW_HIGH:   r_sw_high   <= i_cfg_data[rcsm_pkg::CFG_LVL_W-1:0];
                default: ;
            endcase
        end
    end

    // Switch channels decode straight off the input bus; history advances on transfer.
    rcsm_switch u_left_switch (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_update   (w_in_xfer),
        .i_width    (i_s_axis_tdata[5*rcsm_pkg::CH_W-1:4*rcsm_pkg::CH_W]),
        .i_low      (r_sw_low),
        .i_high     (r_sw_high),
        .o_position (w_lpos),
        .o_edge     (w_ledge)
    );

    rcsm_switch u_right_switch (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_update   (w_in_xfer),
        .i_width    (i_s_axis_tdata[6*rcsm_pkg::CH_W-1:5*rcsm_pkg::CH_W]),
        .i_low      (r_sw_low),
        .i_high     (r_sw_high),
        .o_position (w_rpos),
        .o_edge     (w_redge)
    );

    // |width - center| feeds the multiplier; the sign is applied after the divide
    // so the quotient truncates toward zero.
    assign w_cur_width = r_width[r_chan];
    assign w_mag = (w_cur_width >= r_center) ? (w_cur_width - r_center)
                                             : (r_center - w_cur_width);

    assign w_div_req.start    = (r_state == ST_LAUNCH);
    assign w_div_req.dividend = r_prod;
    assign w_div_req.divisor  = r_half;

    rcsm_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Clamp to stick_max first, then stick_min, then zero the open deadband.
    assign w_hi = $signed({{EXT_W{1'b0}}, r_stick_max});
    assign w_lo = $signed({{SEXT_W{r_stick_min[rcsm_pkg::CFG_MIN_W-1]}}, r_stick_min});
    assign w_db = $signed({{EXT_W{1'b0}}, r_deadband});

    always_comb begin
        if (r_val > w_hi) begin
            w_clamp = w_hi;
        end else if (r_val < w_lo) begin
            w_clamp = w_lo;
        end else begin
            w_clamp = r_val;
        end
        if ((w_clamp < w_db) && (w_clamp > -w_db)) begin
            w_stick_res = '0;
        end else begin
            w_stick_res = w_clamp[rcsm_pkg::STICK_W-1:0];
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_chan  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        r_state <= ST_MUL;
                        r_chan  <= '0;
                    end
                end
                ST_MUL:    r_state <= ST_LAUNCH;
                ST_LAUNCH: r_state <= ST_DIV;
                ST_DIV: begin
                    if (w_div_rsp.done) begin
                        r_state <= ST_POST;
                    end
                end
                ST_POST: begin
                    if (r_chan == CHAN_IDX_W'(rcsm_pkg::NUM_STICKS - 1)) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_chan  <= r_chan + 1'b1;
                        r_state <= ST_MUL;
                    end
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Working data: capture the frame, then the product, quotient and stick value.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            for (int i = 0; i < rcsm_pkg::NUM_STICKS; i++) begin
                r_width[i] <= i_s_axis_tdata[i*rcsm_pkg::CH_W +: rcsm_pkg::CH_W];
            end
            r_lpos  <= w_lpos;
            r_rpos  <= w_rpos;
            r_ledge <= w_ledge;
            r_redge <= w_redge;
            r_flags <= i_s_axis_tuser;
        end
        if (r_state == ST_MUL) begin
            r_prod <= w_mag * r_stick_max;
            r_neg  <= (w_cur_width < r_center);
        end
        if ((r_state == ST_DIV) && w_div_rsp.done) begin
            r_val <= r_neg ? -$signed({1'b0, w_div_rsp.quotient})
                           :  $signed({1'b0, w_div_rsp.quotient});
        end
        if (r_state == ST_POST) begin
            r_stick[r_chan] <= w_stick_res;
        end
    end

    // Output register: load when the frame is done and the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_FIN) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FIN) && w_out_free) begin
            r_out_data <= {{(rcsm_pkg::OUT_DATA_W - rcsm_pkg::OUT_FIELD_W){1'b0}},
                           r_redge, r_ledge, r_rpos, r_lpos,
                           r_stick[3], r_stick[2], r_stick[1], r_stick[0]};
            r_out_user <= r_flags;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // Both switch positions on the output never go past up.
    assign w_pos_ok =
        (r_out_data[4*rcsm_pkg::STICK_W +: rcsm_pkg::SW_W] <= rcsm_pkg::POS_UP) &&
        (r_out_data[4*rcsm_pkg::STICK_W + rcsm_pkg::SW_W +: rcsm_pkg::SW_W] <= rcsm_pkg::POS_UP);

    // Checks
    `RCSM_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, w_in_xfer, !o_s_axis_tready)
    `RCSM_ASSERT_NOW(a_idle_div_quiet, i_clk, i_rst_n, o_s_axis_tready, !w_div_rsp.busy)
    `RCSM_ASSERT_NOW(a_done_in_div, i_clk, i_rst_n, w_div_rsp.done, r_state == ST_DIV)
    `RCSM_ASSERT_NOW(a_switch_codes, i_clk, i_rst_n, o_m_axis_tvalid, w_pos_ok)

endmodule

FILE: verif/rcsm_frame_checker.sv
// Frame checker for the RC stick and switch mapper: predicts every frame result and compares it.
`timescale 1ns / 100ps

module rcsm_frame_checker
    import rcsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // right_x_width .. right_switch_width
    input  logic [USER_W-1:0]     i_s_tuser,   // lost_in, failsafe_in
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,   // sticks, positions, edges, zero fill
    input  logic [USER_W-1:0]     i_m_tuser,   // lost_out, failsafe_out
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int MAX_PRINTED = 40;
    localparam int FILL_W      = OUT_DATA_W - OUT_FIELD_W;

    typedef struct packed {
        logic [STICK_W-1:0] right_x;
        logic [STICK_W-1:0] right_y;
        logic [STICK_W-1:0] left_y;
        logic [STICK_W-1:0] left_x;
        logic [SW_W-1:0]    left_pos;
        logic [SW_W-1:0]    right_pos;
        logic [SW_W-1:0]    left_edge;
        logic [SW_W-1:0]    right_edge;
        logic               lost;
        logic               failsafe;
    } frame_result_t;

    logic [CFG_LVL_W-1:0]        center_q;
    logic [CFG_LVL_W-1:0]        half_q;
    logic [CFG_MAX_W-1:0]        max_q;
    logic signed [CFG_MIN_W-1:0] min_q;
    logic [CFG_MAX_W-1:0]        band_q;
    logic [CFG_LVL_W-1:0]        low_q;
    logic [CFG_LVL_W-1:0]        high_q;
    logic [SW_W-1:0]             left_hist;
    logic [SW_W-1:0]             right_hist;

    frame_result_t expected_frames[$];
    int            results_seen = 0;

    // Scale, clamp (upper bound first), then zero the open deadband.
    function automatic logic [STICK_W-1:0] scale_stick(input logic [CH_W-1:0] width);
        longint offset;
        longint divisor;
        longint upper;
        longint lower;
        longint band;
        longint value;
        offset  = longint'(width) - longint'(center_q);
        divisor = longint'(half_q);
        if (divisor == 0)
            divisor = 1;
        upper = longint'(max_q);
        lower = longint'(min_q);
        band  = longint'(band_q);
        value = offset * upper / divisor;
        if (value > upper)
            value = upper;
        else if (value < lower)
            value = lower;
        if (value < band && value > -band)
            value = 0;
        return value[STICK_W-1:0];
    endfunction

    // Below-low wins over above-high when the levels cross.
    function automatic logic [SW_W-1:0] switch_position(input logic [CH_W-1:0] width);
        if (width < low_q)
            return POS_DOWN;
        if (width > high_q)
            return POS_UP;
        return POS_MID;
    endfunction

    function automatic logic [SW_W-1:0] switch_edge(input logic [SW_W-1:0] held,
                                                    input logic [SW_W-1:0] fresh);
        if (fresh > held)
            return EDGE_RISE;
        if (fresh < held)
            return EDGE_FALL;
        return EDGE_NONE;
    endfunction

    // Map one frame and advance both switch histories.
    function automatic frame_result_t map_frame(input logic [IN_DATA_W-1:0] widths,
                                                input logic [USER_W-1:0]    flags);
        frame_result_t r;
        r.right_x    = scale_stick(widths[0*CH_W +: CH_W]);
        r.right_y    = scale_stick(widths[1*CH_W +: CH_W]);
        r.left_y     = scale_stick(widths[2*CH_W +: CH_W]);
        r.left_x     = scale_stick(widths[3*CH_W +: CH_W]);
        r.left_pos   = switch_position(widths[4*CH_W +: CH_W]);
        r.right_pos  = switch_position(widths[5*CH_W +: CH_W]);
        r.left_edge  = switch_edge(left_hist, r.left_pos);
        r.right_edge = switch_edge(right_hist, r.right_pos);
        r.lost       = flags[0];
        r.failsafe   = flags[1];
        left_hist    = r.left_pos;
        right_hist   = r.right_pos;
        return r;
    endfunction

    task automatic report_failure(input string msg);
        if (o_fail_count < MAX_PRINTED)
            $display("%0t ns: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [STICK_W-1:0] got,
                               input logic [STICK_W-1:0] want);
        if (got !== want)
            report_failure($sformatf("result %0d: %s is %0h, expected %0h",
                                     results_seen, name, got, want));
    endtask

    task automatic compare_frame(input frame_result_t want);
        logic [SW_W-1:0] field;
        check_field("right_x", i_m_tdata[0*STICK_W +: STICK_W], want.right_x);
        check_field("right_y", i_m_tdata[1*STICK_W +: STICK_W], want.right_y);
        check_field("left_y",  i_m_tdata[2*STICK_W +: STICK_W], want.left_y);
        check_field("left_x",  i_m_tdata[3*STICK_W +: STICK_W], want.left_x);
        field = i_m_tdata[4*STICK_W +: SW_W];
        check_field("left_position", STICK_W'(field), STICK_W'(want.left_pos));
        field = i_m_tdata[4*STICK_W + SW_W +: SW_W];
        check_field("right_position", STICK_W'(field), STICK_W'(want.right_pos));
        field = i_m_tdata[4*STICK_W + 2*SW_W +: SW_W];
        check_field("left_edge", STICK_W'(field), STICK_W'(want.left_edge));
        field = i_m_tdata[4*STICK_W + 3*SW_W +: SW_W];
        check_field("right_edge", STICK_W'(field), STICK_W'(want.right_edge));
        check_field("lost_out", STICK_W'(i_m_tuser[0]), STICK_W'(want.lost));
        check_field("failsafe_out", STICK_W'(i_m_tuser[1]), STICK_W'(want.failsafe));
        check_field("zero fill", STICK_W'(i_m_tdata[OUT_DATA_W-1 -: FILL_W]), '0);
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            center_q   = 12'd1500;
            half_q     = 12'd500;
            max_q      = 14'd1000;
            min_q      = -15'sd1000;
            band_q     = 14'd10;
            low_q      = 12'd1250;
            high_q     = 12'd1750;
            left_hist  = POS_DOWN;
            right_hist = POS_DOWN;
            expected_frames.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_CENTER:    center_q = i_cfg_data[CFG_LVL_W-1:0];
                    REG_HALF:      half_q   = i_cfg_data[CFG_LVL_W-1:0];
                    REG_STICK_MAX: max_q    = i_cfg_data[CFG_MAX_W-1:0];
                    REG_STICK_MIN: min_q    = i_cfg_data[CFG_MIN_W-1:0];
                    REG_DEADBAND:  band_q   = i_cfg_data[CFG_MAX_W-1:0];
                    REG_SW_LOW:    low_q    = i_cfg_data[CFG_LVL_W-1:0];
                    REG_SW_HIGH:   high_q   = i_cfg_data[CFG_LVL_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                expected_frames.push_back(map_frame(i_s_tdata, i_s_tuser));
            if (i_m_tvalid && i_m_tready) begin
                results_seen++;
                if (expected_frames.size() == 0)
                    report_failure($sformatf("result %0d arrived with no frame waiting",
                                             results_seen));
                else
                    compare_frame(expected_frames.pop_front());
            end
        end
        o_pending = expected_frames.size();
    end

endmodule

FILE: verif/tb_rc_channel_stick_switch_mapper_unit.sv
// Testbench top for the RC stick and switch mapper: drives frames and settings, gives the verdict.
`timescale 1ns / 100ps

module tb_rc_channel_stick_switch_mapper_unit;
    import rcsm_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int DIRECTED      = 24;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int NUM_PHASES    = 11;
    // Drain time at the end, a little longer than the output takes to appear after the input transfer.
    localparam int DRAIN_CYCLES  = 130;
    // Slowest legal frame: its work plus the longest input gap and the longest receiver hold-off,
    // times ~1280 frames, taken about five times over.
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int WIDTH_MAX     = (1 << CH_W) - 1;
    // Index 7 decodes to no register; one write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    // Receiver patterns.
    localparam int READY_ALWAYS   = 0;
    localparam int READY_RANDOM   = 1;
    localparam int READY_HELD_OFF = 2;

    logic                  i_clk;
    logic                  i_rst_n   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;   // right_x_width .. right_switch_width
    logic [USER_W-1:0]     s_tuser   = '0;   // lost_in, failsafe_in
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // sticks, positions, edges, zero fill
    logic [USER_W-1:0]     m_tuser;          // lost_out, failsafe_out

    int fail_count;
    int frames_pending;
    int cycle_count;
    int burst_left  = 0;
    int stall_left  = 0;
    int stall_mode  = READY_ALWAYS;

    // Copies of the levels that steer the random widths toward the interesting regions.
    int cfg_center  = 1500;
    int cfg_half    = 500;
    int cfg_low     = 1250;
    int cfg_high    = 1750;

    rc_channel_stick_switch_mapper_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    rcsm_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (frames_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog: end the run with an error once the cycle limit is reached.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: alternate stretches of steady ready, coin-flip ready and long hold-offs.
    // Change ready only on the falling edge so the block sees it settled.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(READY_ALWAYS, READY_HELD_OFF);
            if (stall_mode == READY_HELD_OFF)
                stall_left = $urandom_range(1, 150);
            else
                stall_left = $urandom_range(20, 400);
        end
        stall_left--;
        case (stall_mode)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_RANDOM: m_tready <= 1'($urandom_range(0, 1));
            default:      m_tready <= 1'b0;
        endcase
    end

    function automatic int clip_width(input int width);
        if (width < 0)
            return 0;
        if (width > WIDTH_MAX)
            return WIDTH_MAX;
        return width;
    endfunction

    // Mostly land around the center, a bit past full scale on both sides, so the linear
    // region, truncation, deadband and both clamps all get hit.
    function automatic int pick_stick_width();
        int span;
        int offset;
        span   = cfg_half + cfg_half / 4 + 2;
        offset = $urandom_range(0, 2 * span);
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, WIDTH_MAX);
        return clip_width(cfg_center + offset - span);
    endfunction

    // Hit each threshold exactly and one or two off, plus the band between the levels.
    function automatic int pick_switch_width();
        int nudge;
        nudge = $urandom_range(0, 4);
        nudge = nudge - 2;
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, WIDTH_MAX);
            1:       return clip_width(cfg_low + nudge);
            2:       return clip_width(cfg_high + nudge);
            default: return $urandom_range(cfg_high, cfg_low);
        endcase
    endfunction

    // Call on a falling edge; leave the write enable high so back-to-back writes
    // never lower and raise it in the same step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge i_clk);
    endtask

    // Write all seven registers, then drop the enable.
    task automatic program_setting(input int center, input int half, input int stick_top,
                                   input int stick_bottom, input int band, input int low,
                                   input int high);
        write_reg(REG_CENTER,    CFG_DATA_W'(center));
        write_reg(REG_HALF,      CFG_DATA_W'(half));
        write_reg(REG_STICK_MAX, CFG_DATA_W'(stick_top));
        write_reg(REG_STICK_MIN, CFG_DATA_W'(stick_bottom));
        write_reg(REG_DEADBAND,  CFG_DATA_W'(band));
        write_reg(REG_SW_LOW,    CFG_DATA_W'(low));
        write_reg(REG_SW_HIGH,   CFG_DATA_W'(high));
        cfg_wr_en <= 1'b0;
        @(negedge i_clk);
        cfg_center = center & WIDTH_MAX;
        cfg_half   = half & WIDTH_MAX;
        cfg_low    = low & WIDTH_MAX;
        cfg_high   = high & WIDTH_MAX;
    endtask

    // Offer one frame in bursts of random length; between bursts hold valid low for a
    // random gap, sometimes longer than a whole frame's processing.
    task automatic send_frame(input logic [IN_DATA_W-1:0] frame, input logic [USER_W-1:0] flags);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            else if ($urandom_range(0, 7) == 0)
                gap = $urandom_range(100, 180);
            else
                gap = $urandom_range(1, 20);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        s_tdata  <= frame;
        s_tuser  <= flags;
        s_tvalid <= 1'b1;
        // Hold the frame until the transfer happens.
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
    endtask

    // Drop valid and wait until every frame in flight has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (frames_pending != 0)
            @(negedge i_clk);
    endtask

    initial begin
        int item;
        int phase;
        int k;
        int stick_pts[12];
        int switch_pts[12];
        logic [IN_DATA_W-1:0] frame;

        // Reset settings: center 1500, half range 500, limits +/-1000, deadband 10.
        // Rails, exact center, both deadband edges, full scale and just past it.
        stick_pts  = '{0, 4095, 1500, 1504, 1505, 1495, 1496, 2000, 1000, 1507, 1493, 2001};
        // Levels 1250/1750: steps down->mid->up and back, repeats for no-edge, and each
        // threshold exactly and one past it.
        switch_pts = '{0, 1300, 1800, 1800, 1250, 1249, 1750, 1751, 4095, 1500, 0, 0};

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed frames at the reset settings; rotate the points across the channels
        // and walk all four flag combinations.
        for (item = 0; item < DIRECTED; item++) begin
            frame = '0;
            for (k = 0; k < NUM_STICKS; k++)
                frame[k*CH_W +: CH_W] = CH_W'(stick_pts[(item + 3 * k) % 12]);
            frame[4*CH_W +: CH_W] = CH_W'(switch_pts[item % 12]);
            frame[5*CH_W +: CH_W] = CH_W'(switch_pts[(item + 3) % 12]);
            send_frame(frame, USER_W'(item));
        end

        // Random frames under a series of settings, reprogrammed only while idle.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            wait_idle();
            case (phase)
                // Low extremes: zero half range (acts as one), widest limits, no deadband.
                0: begin
                    write_reg(REG_SPARE, CFG_DATA_W'($urandom));
                    program_setting(0, 0, 16383, -16384, 0, 0, WIDTH_MAX);
                end
                // High extremes: zero stick max, full deadband, crossed switch levels.
                1: program_setting(WIDTH_MAX, WIDTH_MAX, 0, 0, 16383, WIDTH_MAX, 0);
                // Lower clamp above the upper clamp, tiny half range.
                2: program_setting(2048, 1, 100, 3000, 50, 2000, 1000);
                // Back to the usual transmitter settings, written explicitly.
                3: program_setting(1500, 500, 1000, -1000, 10, 1250, 1750);
                default: begin
                    if (phase % 2 == 1)
                        // Raw words: upper bits above each register's width are junk.
                        program_setting($urandom_range(0, 32767), $urandom_range(0, 32767),
                                        $urandom_range(0, 32767), $urandom_range(0, 32767),
                                        $urandom_range(0, 32767), $urandom_range(0, 32767),
                                        $urandom_range(0, 32767));
                    else
                        program_setting($urandom_range(1000, 2000), $urandom_range(1, 1000),
                                        $urandom_range(1, 16383),
                                        -int'($urandom_range(0, 16384)),
                                        $urandom_range(0, 200), $urandom_range(900, 1500),
                                        $urandom_range(1500, 2100));
                end
            endcase
            for (item = 0; item < RANDOM_ITEMS / NUM_PHASES + 1; item++) begin
                frame = '0;
                for (k = 0; k < NUM_STICKS; k++)
                    frame[k*CH_W +: CH_W] = CH_W'(pick_stick_width());
                for (k = NUM_STICKS; k < NUM_CHANS; k++)
                    frame[k*CH_W +: CH_W] = CH_W'(pick_switch_width());
                send_frame(frame, USER_W'($urandom_range(0, 3)));
            end
        end

        // Drain, then give any stray result time to show up.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && frames_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/rcsm_pkg.sv
hdl/rcsm_divider.sv
hdl/rcsm_switch.sv
hdl/rc_channel_stick_switch_mapper_unit.sv
verif/rcsm_frame_checker.sv
verif/tb_rc_channel_stick_switch_mapper_unit.sv
